>>> rtl/rfp_pkg.sv
`default_nettype none

package rfp_pkg;

    // Frame framing bytes
    localparam logic [7:0] END_MARK     = 8'h6B;
    localparam logic [7:0] CMD_VELOCITY = 8'h35;
    localparam logic [7:0] CMD_POSITION = 8'h36;

    // Frame lengths in bytes
    localparam logic [3:0] LEN_VELOCITY = 4'd6;
    localparam logic [3:0] LEN_POSITION = 4'd8;
    localparam logic [3:0] LEN_ACK      = 4'd4;

    // Byte count bound; the 4-bit count stays below it, so the count restarts only when a frame completes
    localparam int MAX_FRAME_BYTES = 16;

    // Frame store depth and index width
    localparam int FRAME_DEPTH = 8;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

    // Queue between classifier and decoder
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Reply type codes
    localparam logic [1:0] TYPE_ACK      = 2'd0;
    localparam logic [1:0] TYPE_VELOCITY = 2'd1;
    localparam logic [1:0] TYPE_POSITION = 2'd2;

    // Configuration register indexes
    localparam logic REG_MOTOR_ADDRESS    = 1'b0;
    localparam logic REG_EXPECTED_COMMAND = 1'b1;

    typedef struct packed {
        logic [7:0]  address;
        logic [7:0]  command;
        logic [1:0]  kind;
        logic [7:0]  status;
        logic [31:0] raw;
    } frame_t;

    typedef struct packed {
        logic [7:0] motor_address;
        logic [7:0] expected_command;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  address;
        logic [7:0]  command;
        logic [1:0]  kind;
        logic [7:0]  status;
        logic        negative;
        logic [31:0] magnitude;
        logic        valid;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/rfp_front.sv
`default_nettype none

// Collect bytes, size the frame from its command byte, and forward
// completed frames with a good end mark to the queue.
module rfp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            q_full,
    output logic                 full,
    output logic                 q_push,
    output rfp_pkg::frame_t      q_data
);

    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [3:0] count_base;
    logic [3:0] count_inc;
    logic [3:0] frame_len;
    logic       accept;
    logic       done;
    logic [7:0] frame_reg [rfp_pkg::FRAME_DEPTH];

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        if (32'(count_reg) >= 32'(rfp_pkg::MAX_FRAME_BYTES))
        begin
            count_base = 4'd0;
        end
        else
        begin
            count_base = count_reg;
        end
        count_inc = count_base + 4'd1;

        unique case (frame_reg[1])
            rfp_pkg::CMD_VELOCITY: frame_len = rfp_pkg::LEN_VELOCITY;
            rfp_pkg::CMD_POSITION: frame_len = rfp_pkg::LEN_POSITION;
            default:               frame_len = rfp_pkg::LEN_ACK;
        endcase

        done       = (count_inc == frame_len);
        count_next = done ? 4'd0 : count_inc;
        q_push     = accept && done && (rx_byte == rfp_pkg::END_MARK);

        q_data.address = frame_reg[0];
        q_data.command = frame_reg[1];
        q_data.status  = frame_reg[2];
        unique case (frame_len)
            rfp_pkg::LEN_VELOCITY:
            begin
                q_data.kind = rfp_pkg::TYPE_VELOCITY;
                q_data.raw  = {16'd0, frame_reg[3], frame_reg[4]};
            end
            rfp_pkg::LEN_POSITION:
            begin
                q_data.kind = rfp_pkg::TYPE_POSITION;
                q_data.raw  = {frame_reg[3], frame_reg[4], frame_reg[5], frame_reg[6]};
            end
            default:
            begin
                q_data.kind = rfp_pkg::TYPE_ACK;
                q_data.raw  = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg[count_base[rfp_pkg::FRAME_AW-1:0]] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rfp_queue.sv
`default_nettype none

// Small frame queue between the classifier and the decoder.
module rfp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire rfp_pkg::frame_t wr_data,
    input  wire logic            rd_en,
    output rfp_pkg::frame_t      rd_data,
    output logic                 full,
    output logic                 empty
);

    logic [rfp_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [rfp_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [rfp_pkg::QUEUE_AW:0]   fill_reg;
    rfp_pkg::frame_t              mem [rfp_pkg::QUEUE_DEPTH];
    logic                         do_wr;
    logic                         do_rd;

    assign full    = (fill_reg == (rfp_pkg::QUEUE_AW+1)'(rfp_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rfp_back.sv
`default_nettype none

// Check the frame against the configured address and, for acknowledge frames,
// the command, derive the sign flag, and hold the result until it is popped.
module rfp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rfp_pkg::cfg_t   cfg,
    input  wire rfp_pkg::frame_t q_data,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output rfp_pkg::result_t     result
);

    logic             out_valid_reg;
    rfp_pkg::result_t out_reg;
    rfp_pkg::result_t out_next;
    logic             is_ack;

    assign q_pop  = !q_empty && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign is_ack = (q_data.kind == rfp_pkg::TYPE_ACK);

    always_comb
    begin
        out_next.address   = q_data.address;
        out_next.command   = q_data.command;
        out_next.kind      = q_data.kind;
        out_next.status    = q_data.status;
        out_next.magnitude = q_data.raw;
        out_next.negative  = !is_ack && (q_data.status != 8'd0);
        out_next.valid     = (q_data.address == cfg.motor_address)
                             && (!is_ack || (q_data.command == cfg.expected_command));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/reply_frame_parser_unit.sv
// Reply frame parser: one received byte per cycle while full is low.
// A decoded reply is written to a queue entry when the byte carrying its end mark is accepted,
// then moves to the result register and shows on the result ports once that register is free.
// Throughput is set by the byte store and count in the front part: one byte per cycle;
// the input stalls only while the queue holds two frames behind an unpopped result.
// Reset clears the byte count, empties the queue and the result register, and
// loads motor_address = 1 and expected_command = 0.
`default_nettype none

module reply_frame_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Byte input, queue style
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,

    // Decoded reply output, queue style
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       reply_address,
    output logic [7:0]       reply_command,
    output logic [1:0]       reply_type,
    output logic [7:0]       status_byte,
    output logic             negative,
    output logic [31:0]      magnitude,
    output logic             reply_valid,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    rfp_pkg::cfg_t    cfg_reg;
    rfp_pkg::frame_t  front_data;
    rfp_pkg::frame_t  head_data;
    rfp_pkg::result_t result;
    logic             front_push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             cfg_wr;

    // Configuration registers: word address selects the register, the byte
    // offset bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_address    <= 8'd1;
            cfg_reg.expected_command <= 8'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                rfp_pkg::REG_MOTOR_ADDRESS:    cfg_reg.motor_address    <= pwdata[7:0];
                rfp_pkg::REG_EXPECTED_COMMAND: cfg_reg.expected_command <= pwdata[7:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rfp_pkg::REG_MOTOR_ADDRESS:    prdata = {24'd0, cfg_reg.motor_address};
            rfp_pkg::REG_EXPECTED_COMMAND: prdata = {24'd0, cfg_reg.expected_command};
            default:                       prdata = 32'd0;
        endcase
    end

    // Front: count and store bytes, size the frame, drop bad end marks.
    rfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .q_full  (q_full),
        .full    (full),
        .q_push  (front_push),
        .q_data  (front_data)
    );

    // Hold classified frames so the front keeps taking bytes while the
    // result side stalls.
    rfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_data),
        .rd_en   (q_pop),
        .rd_data (head_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: validity check and result register.
    rfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_data  (head_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign reply_address = result.address;
    assign reply_command = result.command;
    assign reply_type    = result.kind;
    assign status_byte   = result.status;
    assign negative      = result.negative;
    assign magnitude     = result.magnitude;
    assign reply_valid   = result.valid;

endmodule

`default_nettype wire
